FILE: src/yuv420_nearest_neighbor_downscaler_core_assert.svh
// Assertion macros for the YUV 4:2:0 downscaler RTL.
// Included by yuvds_walk, which carries the concurrent checks; no other dependencies.
`ifndef YUV420_NEAREST_NEIGHBOR_DOWNSCALER_CORE_ASSERT_SVH
`define YUV420_NEAREST_NEIGHBOR_DOWNSCALER_CORE_ASSERT_SVH
`ifndef SYNTH
// Check on every clock edge outside reset.
`define YUVDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define YUVDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define YUVDS_ASSERT(lbl, clk, rst, prop, msg)
`define YUVDS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/yuvds_pkg.sv
// Shared types, constants and size helpers for the YUV 4:2:0 downscaler.
// No dependencies.
`default_nettype none
package yuvds_pkg;

  localparam int CFG_W   = 13;
  localparam int PIX_W   = 8;
  localparam int PLANE_W = 2;
  localparam int IDX_W   = 3;
  localparam int ERR_W   = CFG_W + 3;
  localparam int DEF_MAX_DIMENSION = 4096;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  localparam logic [IDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_W = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_H = 3'd3;

  localparam logic [CFG_W-1:0] RST_SRC_W = 13'd1920;
  localparam logic [CFG_W-1:0] RST_SRC_H = 13'd1080;
  localparam logic [CFG_W-1:0] RST_DST_W = 13'd720;
  localparam logic [CFG_W-1:0] RST_DST_H = 13'd480;

  typedef struct packed {
    logic [CFG_W-1:0] sw;
    logic [CFG_W-1:0] sh;
    logic [CFG_W-1:0] dw;
    logic [CFG_W-1:0] dh;
  } dims_t;

  typedef struct packed {
    dims_t luma;
    dims_t chroma;
    logic  restart;
  } cfg_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [PLANE_W-1:0] plane;
    logic               line_end;
    logic               frame_end;
  } res_t;

  // Clamp to [2, hi] and clear bit 0.
  function automatic logic [CFG_W-1:0] clamp_even(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W:0] hi);
    logic [CFG_W:0] t;
    t = {1'b0, v};
    if (t < (CFG_W+1)'(2)) t = (CFG_W+1)'(2);
    if (t > hi) t = hi;
    return {t[CFG_W-1:1], 1'b0};
  endfunction

  function automatic dims_t luma_dims(input dims_t raw, input logic [CFG_W:0] hi);
    dims_t d;
    d.sw = clamp_even(raw.sw, hi);
    d.sh = clamp_even(raw.sh, hi);
    d.dw = clamp_even(raw.dw, {1'b0, d.sw});
    d.dh = clamp_even(raw.dh, {1'b0, d.sh});
    return d;
  endfunction

  function automatic dims_t half_dims(input dims_t d);
    dims_t h;
    h.sw = d.sw >> 1;
    h.sh = d.sh >> 1;
    h.dw = d.dw >> 1;
    h.dh = d.dh >> 1;
    return h;
  endfunction

endpackage
`default_nettype wire

FILE: src/yuv420_nearest_neighbor_downscaler_core.sv
// Top level of the YUV 4:2:0 nearest-neighbor downscaler.
// Depends on yuvds_pkg, yuvds_cfg, yuvds_walk and yuvds_outreg.
//
// Channel   Handshake                 Payload
// config    cfg_write                 cfg_index, cfg_data
// input     in_valid / in_ready       pixel_in, frame_start
// output    out_valid / out_ready     pixel_out, plane_out, line_end, frame_end
//
// One item per cycle sustained while the result register is free; a kept sample
// passes the input stage and then the result register to reach the outputs.
// The error-term update of the walk is combinational, which sets the rate.
// rst is synchronous and active high; sizes return to 1920x1080 -> 720x480.
// A size write restarts the stream at the Y plane origin; sizes pass the raw and
// effective-size registers. out_ready low holds the result and stalls the input.
`default_nettype none
module yuv420_nearest_neighbor_downscaler_core
  import yuvds_pkg::*;
#(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PIX_W-1:0]   pixel_in,
  input  wire logic               frame_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PIX_W-1:0]        pixel_out,
  output logic [PLANE_W-1:0]      plane_out,
  output logic                    line_end,
  output logic                    frame_end
);

  cfg_ctl_t ctl;
  res_t     res;
  res_t     res_q;
  logic     load;
  logic     out_free;

  yuvds_cfg #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctl      (ctl)
  );

  yuvds_walk #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (ctl),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .frame_start(frame_start),
    .out_free   (out_free),
    .load       (load),
    .res        (res)
  );

  yuvds_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .d        (res),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .free     (out_free),
    .q        (res_q)
  );

  assign pixel_out = res_q.pixel;
  assign plane_out = res_q.plane;
  assign line_end  = res_q.line_end;
  assign frame_end = res_q.frame_end;

endmodule
`default_nettype wire

FILE: src/yuvds_cfg.sv
// Size registers of the downscaler and the registered effective plane sizes.
// Depends on yuvds_pkg.
`default_nettype none
module yuvds_cfg
  import yuvds_pkg::*;
#(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output cfg_ctl_t              ctl
);

  localparam logic [CFG_W:0] MaxHi = (CFG_W+1)'(MAX_DIMENSION);

  dims_t raw;
  dims_t luma;
  dims_t chroma;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw.sw <= RST_SRC_W;
      raw.sh <= RST_SRC_H;
      raw.dw <= RST_DST_W;
      raw.dh <= RST_DST_H;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SRC_W: raw.sw <= cfg_data;
        REG_SRC_H: raw.sh <= cfg_data;
        REG_DST_W: raw.dw <= cfg_data;
        REG_DST_H: raw.dh <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Effective sizes are registered from the raw registers, in the cycle after them.
  always_ff @(posedge clk) begin
    if (rst) begin
      luma   <= luma_dims({RST_SRC_W, RST_SRC_H, RST_DST_W, RST_DST_H}, MaxHi);
      chroma <= half_dims(luma_dims({RST_SRC_W, RST_SRC_H, RST_DST_W, RST_DST_H},
                                    MaxHi));
    end else begin
      luma   <= luma_dims(raw, MaxHi);
      chroma <= half_dims(luma_dims(raw, MaxHi));
    end
  end

  assign ctl.luma    = luma;
  assign ctl.chroma  = chroma;
  assign ctl.restart = cfg_write && (cfg_index <= REG_DST_H);

endmodule
`default_nettype wire

FILE: src/yuvds_walk.sv
// Input stage and raster walk: plane/row/column counters, error terms, keep decision.
// Depends on yuvds_pkg and the assertion macro header.
`default_nettype none
`include "yuv420_nearest_neighbor_downscaler_core_assert.svh"
module yuvds_walk
  import yuvds_pkg::*;
#(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_ctl_t         cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] pixel_in,
  input  wire logic             frame_start,
  input  wire logic             out_free,
  output logic                  load,
  output res_t                  res
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);

  // input stage
  logic             in_v;
  logic [PIX_W-1:0] pix_q;
  logic             fs_q;
  logic             adv;
  logic             accept;

  // walk state
  logic                    pend;
  logic [PLANE_W-1:0]      plane;
  logic [CNT_W-1:0]        ccount;
  logic [CNT_W-1:0]        rcount;
  logic [CFG_W-1:0]        dcol;
  logic [CFG_W-1:0]        drow;
  logic signed [ERR_W-1:0] cerr;
  logic signed [ERR_W-1:0] rerr;
  logic                    kept;

  logic [PLANE_W-1:0]      plane_next;
  logic [CNT_W-1:0]        ccount_next;
  logic [CNT_W-1:0]        rcount_next;
  logic [CFG_W-1:0]        dcol_next;
  logic [CFG_W-1:0]        drow_next;
  logic signed [ERR_W-1:0] cerr_next;
  logic signed [ERR_W-1:0] rerr_next;
  logic                    kept_next;

  // effective values for the item in the input stage
  logic                    start;
  logic [PLANE_W-1:0]      pl;
  logic [PLANE_W-1:0]      pl_nx;
  logic [CNT_W-1:0]        cc;
  logic [CNT_W-1:0]        rc;
  logic [CFG_W-1:0]        dc;
  logic [CFG_W-1:0]        dr;
  logic signed [ERR_W-1:0] ce;
  logic signed [ERR_W-1:0] re;
  logic                    kp;
  dims_t                   cur;
  dims_t                   nxt;
  dims_t                   state_dims;
  logic signed [ERR_W-1:0] sw2;
  logic signed [ERR_W-1:0] sh2;
  logic signed [ERR_W-1:0] dw2;
  logic signed [ERR_W-1:0] dh2;
  logic signed [ERR_W-1:0] ce_step;
  logic signed [ERR_W-1:0] re_step;
  logic [CFG_W-1:0]        dr_step;
  logic                    emit;
  logic                    le;
  logic                    col_last;
  logic                    row_last;

  assign adv      = in_v && out_free;
  assign in_ready = !in_v || adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    start = pend || fs_q;
    pl    = start ? PLANE_Y : plane;
    cc    = start ? '0 : ccount;
    rc    = start ? '0 : rcount;
    dc    = start ? '0 : dcol;
    dr    = start ? '0 : drow;
    kp    = start ? 1'b1 : kept;
    ce    = start ? $signed(ERR_W'(cfg.luma.dw)) : cerr;
    re    = start ? $signed(ERR_W'(cfg.luma.dh)) : rerr;
    cur   = (pl == PLANE_Y) ? cfg.luma : cfg.chroma;
    pl_nx = (pl == PLANE_V) ? PLANE_Y : pl + PLANE_W'(1);
    nxt   = (pl_nx == PLANE_Y) ? cfg.luma : cfg.chroma;
    sw2   = $signed(ERR_W'({cur.sw, 1'b0}));
    sh2   = $signed(ERR_W'({cur.sh, 1'b0}));
    dw2   = $signed(ERR_W'({cur.dw, 1'b0}));
    dh2   = $signed(ERR_W'({cur.dh, 1'b0}));

    emit = kp && (dc < cur.dw) && !ce[ERR_W-1] && (ce < dw2);
    le   = ((CFG_W+1)'(dc) + (CFG_W+1)'(1)) >= {1'b0, cur.dw};
    col_last = ((CFG_W+1)'(cc) + (CFG_W+1)'(1)) >= {1'b0, cur.sw};
    row_last = ((CFG_W+1)'(rc) + (CFG_W+1)'(1)) >= {1'b0, cur.sh};

    ce_step = ce - dw2 + (emit ? sw2 : '0);
    re_step = re - dh2 + (kp ? sh2 : '0);
    dr_step = dr + CFG_W'(kp);

    res.pixel     = pix_q;
    res.plane     = pl;
    res.line_end  = le;
    res.frame_end = (pl == PLANE_V) && le &&
                    (((CFG_W+1)'(dr) + (CFG_W+1)'(1)) >= {1'b0, cur.dh});
    load = adv && emit;

    plane_next  = pl;
    ccount_next = cc + CNT_W'(1);
    rcount_next = rc;
    dcol_next   = dc + CFG_W'(emit);
    drow_next   = dr;
    cerr_next   = ce_step;
    rerr_next   = re;
    kept_next   = kp;
    if (col_last) begin
      ccount_next = '0;
      dcol_next   = '0;
      cerr_next   = $signed(ERR_W'(cur.dw));
      if (row_last) begin
        // Plane done: move to the next plane origin, wrapping after V.
        plane_next  = pl_nx;
        rcount_next = '0;
        drow_next   = '0;
        cerr_next   = $signed(ERR_W'(nxt.dw));
        rerr_next   = $signed(ERR_W'(nxt.dh));
        kept_next   = 1'b1;
      end else begin
        rcount_next = rc + CNT_W'(1);
        drow_next   = dr_step;
        rerr_next   = re_step;
        kept_next   = (dr_step < cur.dh) && !re_step[ERR_W-1] &&
                      (re_step < dh2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (accept) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q <= pixel_in;
      fs_q  <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      // Error terms load from the sizes when the next item is worked.
      pend   <= 1'b1;
      plane  <= PLANE_Y;
      ccount <= '0;
      rcount <= '0;
      dcol   <= '0;
      drow   <= '0;
      kept   <= 1'b1;
    end else if (adv) begin
      pend   <= 1'b0;
      plane  <= plane_next;
      ccount <= ccount_next;
      rcount <= rcount_next;
      dcol   <= dcol_next;
      drow   <= drow_next;
      kept   <= kept_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cerr <= cerr_next;
      rerr <= rerr_next;
    end
  end

  assign state_dims = (plane == PLANE_Y) ? cfg.luma : cfg.chroma;

  `YUVDS_ASSERT(a_col_range, clk, rst, (CFG_W+1)'(ccount) < {1'b0, state_dims.sw}, "column count past source width")
  `YUVDS_ASSERT(a_row_range, clk, rst, (CFG_W+1)'(rcount) < {1'b0, state_dims.sh}, "row count past source height")
  `YUVDS_ASSERT(a_dcol_range, clk, rst, dcol <= state_dims.dw, "destination column past target width")
  `YUVDS_ASSERT(a_plane_wrap, clk, rst, adv && pl == PLANE_V && col_last && row_last |=> plane == PLANE_Y && rcount == '0, "no wrap to luma after V plane")
  `YUVDS_ASSERT_ALWAYS(a_rst_restart, clk, rst |=> pend, "reset did not arm a stream restart")

endmodule
`default_nettype wire

FILE: src/yuvds_outreg.sv
// Result register of the downscaler: holds one kept sample until it is taken.
// Depends on yuvds_pkg.
`default_nettype none
module yuvds_outreg
  import yuvds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  wire res_t d,
  input  wire logic out_ready,
  output logic      out_valid,
  output logic      free,
  output res_t      q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire
